// ===== rtl/keyed_count_table_unit_assert.svh =====
// Assertion macros used by the keyed count table unit.
`ifndef KEYED_COUNT_TABLE_UNIT_ASSERT_SVH
`define KEYED_COUNT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define KCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kct_pkg.sv =====
// Package with the constants, codes and types of the keyed count table.
package kct_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_BITS = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int USED_W   = $clog2(CAPACITY + 1);
    localparam int CNT_W    = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_RESULT
    } state_t;

    // Access request to the entry store.
    typedef struct packed {
        logic                rd_en;
        logic [SLOT_W-1:0]   rd_addr;
        logic                wr_key_en;
        logic                wr_cnt_en;
        logic [SLOT_W-1:0]   wr_addr;
        logic [KEY_BITS-1:0] wr_key;
        logic [CNT_W-1:0]    wr_cnt;
    } mem_req_t;

endpackage

// ===== rtl/kct_store.sv =====
// Entry store: key memory and count memory, one read and one write port each.
module kct_store (
    input  logic                      clk,
    input  kct_pkg::mem_req_t         req,
    output logic [kct_pkg::KEY_BITS-1:0] rd_key,
    output logic [kct_pkg::CNT_W-1:0]    rd_cnt
);

    logic [kct_pkg::KEY_BITS-1:0] key_mem [kct_pkg::CAPACITY];
    logic [kct_pkg::CNT_W-1:0]    cnt_mem [kct_pkg::CAPACITY];

    // Key memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (req.wr_key_en)
        begin
            key_mem[req.wr_addr] <= req.wr_key;
        end
        if (req.rd_en)
        begin
            rd_key <= key_mem[req.rd_addr];
        end
    end

    // Count memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (req.wr_cnt_en)
        begin
            cnt_mem[req.wr_addr] <= req.wr_cnt;
        end
        if (req.rd_en)
        begin
            rd_cnt <= cnt_mem[req.rd_addr];
        end
    end

endmodule

// ===== rtl/keyed_count_table_unit.sv =====
// Keyed count table: a fixed-capacity map from item keys to saturating counts.
//
// Request channel (s_*): s_tuser carries the opcode (add, update, query) and
// s_tdata carries the item key and the signed quantity. A request is taken
// when s_tvalid and s_tready are both high; s_tready is high only while the
// block has no request in work, so requests are handled one at a time.
// Result channel (m_*): m_tuser carries the status and m_tdata the count.
// Each request gives exactly one result.
//
// Timing: the key search reads the used slots in order, one per cycle through
// the store's registered read port, compares each key as it returns and ends
// at the first match or at the fill count; the apply step then writes the store
// and the result register, and the next request is taken after the result state.
// The result waits in an output register; a new request is accepted while it
// waits, and a stalled m_tready only holds the block once the next result is
// ready and the register is still occupied.
// Reset empties the table at once (the fill count goes to zero); the stored
// keys and counts are not cleared, since only slots below the fill count are
// ever read.
module keyed_count_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [63:0] item_key, [95:64] quantity
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] count_out
    output logic [1:0]  m_tuser    // [1:0] status
);

    `include "keyed_count_table_unit_assert.svh"

    kct_pkg::state_t state_reg, state_next;
    logic [kct_pkg::USED_W-1:0]   used_reg, used_next;
    logic                         pend_reg, pend_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    logic [1:0]                   op_reg, op_next;
    logic [kct_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [kct_pkg::CNT_W-1:0]    qty_reg, qty_next;
    logic [kct_pkg::USED_W-1:0]   idx_reg, idx_next;
    logic [kct_pkg::SLOT_W-1:0]   last_reg, last_next;
    logic                         hit_reg, hit_next;
    logic [kct_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [kct_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    kct_pkg::status_t             res_status_reg, res_status_next;
    logic [kct_pkg::CNT_W-1:0]    res_count_reg, res_count_next;
    kct_pkg::status_t             m_status_reg, m_status_next;
    logic [kct_pkg::CNT_W-1:0]    m_count_reg, m_count_next;

    kct_pkg::mem_req_t            mem_req;
    logic [kct_pkg::KEY_BITS-1:0] rd_key;
    logic [kct_pkg::CNT_W-1:0]    rd_cnt;

    logic                         hit;
    logic                         scan_end;
    logic                         out_free;
    logic                         in_accept;
    logic [kct_pkg::CNT_W:0]      sum_wide;
    logic [kct_pkg::CNT_W-1:0]    sum_sat;

    kct_store u_store (
        .clk    (clk),
        .req    (mem_req),
        .rd_key (rd_key),
        .rd_cnt (rd_cnt)
    );

    // Handshake and search status.
    assign s_tready  = (state_reg == kct_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign hit       = pend_reg && (rd_key == key_reg);
    assign scan_end  = (idx_reg == used_reg);

    // Saturating add of the quantity onto the stored count.
    assign sum_wide = {cnt_reg[kct_pkg::CNT_W-1], cnt_reg}
                    + {qty_reg[kct_pkg::CNT_W-1], qty_reg};
    always_comb
    begin
        if (sum_wide[kct_pkg::CNT_W] != sum_wide[kct_pkg::CNT_W-1])
        begin
            sum_sat = sum_wide[kct_pkg::CNT_W]
                    ? {1'b1, {(kct_pkg::CNT_W-1){1'b0}}}
                    : {1'b0, {(kct_pkg::CNT_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[kct_pkg::CNT_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kct_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = kct_pkg::S_SCAN;
                end
            end
            kct_pkg::S_SCAN:
            begin
                if (hit || scan_end)
                begin
                    state_next = kct_pkg::S_APPLY;
                end
            end
            kct_pkg::S_APPLY:
            begin
                state_next = kct_pkg::S_RESULT;
            end
            kct_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = kct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kct_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, store requests and result register.
    always_comb
    begin
        used_next       = used_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        qty_next        = qty_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        mem_req           = '0;
        mem_req.rd_addr   = idx_reg[kct_pkg::SLOT_W-1:0];
        mem_req.wr_key    = key_reg;

        case (state_reg)
            kct_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = s_tuser;
                    key_next  = s_tdata[kct_pkg::KEY_BITS-1:0];
                    qty_next  = s_tdata[95:64];
                    idx_next  = '0;
                    pend_next = 1'b0;
                end
            end
            kct_pkg::S_SCAN:
            begin
                // Compare the slot read last cycle while the next one is read.
                if (hit)
                begin
                    hit_next  = 1'b1;
                    slot_next = last_reg;
                    cnt_next  = rd_cnt;
                    pend_next = 1'b0;
                end
                else if (scan_end)
                begin
                    hit_next  = 1'b0;
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    last_next     = idx_reg[kct_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                    pend_next     = 1'b1;
                end
            end
            kct_pkg::S_APPLY:
            begin
                res_status_next = kct_pkg::STAT_DONE;
                res_count_next  = '0;
                mem_req.wr_addr = slot_reg;
                case (op_reg)
                    kct_pkg::OP_ADD:
                    begin
                        if (hit_reg)
                        begin
                            mem_req.wr_cnt_en = 1'b1;
                            mem_req.wr_cnt    = sum_sat;
                            res_count_next    = sum_sat;
                        end
                        else if (used_reg < kct_pkg::USED_W'(kct_pkg::CAPACITY))
                        begin
                            // New key goes into the next free slot.
                            mem_req.wr_addr   = used_reg[kct_pkg::SLOT_W-1:0];
                            mem_req.wr_key_en = 1'b1;
                            mem_req.wr_cnt_en = 1'b1;
                            mem_req.wr_cnt    = qty_reg;
                            used_next         = used_reg + 1'b1;
                            res_count_next    = qty_reg;
                        end
                        else
                        begin
                            res_status_next = kct_pkg::STAT_FULL;
                        end
                    end
                    kct_pkg::OP_UPDATE:
                    begin
                        if (hit_reg)
                        begin
                            mem_req.wr_cnt_en = 1'b1;
                            mem_req.wr_cnt    = qty_reg;
                            res_count_next    = qty_reg;
                        end
                        else
                        begin
                            res_status_next = kct_pkg::STAT_NOT_FOUND;
                        end
                    end
                    kct_pkg::OP_QUERY:
                    begin
                        if (hit_reg)
                        begin
                            res_count_next = cnt_reg;
                        end
                        else
                        begin
                            res_status_next = kct_pkg::STAT_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // Reserved opcode: no change, plain done result.
                        res_status_next = kct_pkg::STAT_DONE;
                    end
                endcase
            end
            kct_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_count_next  = res_count_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kct_pkg::S_IDLE;
            used_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        qty_reg        <= qty_next;
        idx_reg        <= idx_next;
        last_reg       <= last_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_count_reg;

    // Checks on the fill count, the search and the result hand-off.
    `KCT_ASSERT_IMP(a_used_in_range, 1'b1,
        used_reg <= kct_pkg::USED_W'(kct_pkg::CAPACITY), "fill count above capacity")
    `KCT_ASSERT_NEXT(a_used_only_in_apply, state_reg != kct_pkg::S_APPLY,
        $stable(used_reg), "fill count changed outside the apply step")
    `KCT_ASSERT_IMP(a_read_below_used, mem_req.rd_en,
        idx_reg < used_reg, "search read a slot beyond the fill count")
    `KCT_ASSERT_NEXT(a_result_loaded, (state_reg == kct_pkg::S_RESULT) && out_free,
        m_tvalid_reg, "finished result not loaded into the output register")

endmodule

// ===== test/keyed_count_checker.sv =====
// Checker for the keyed count table: predicts each result and compares it with the block.
module keyed_count_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // [63:0] item_key, [95:64] quantity
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] count_out
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fault_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [kct_pkg::CNT_W-1:0] COUNT_MAX =
        {1'b0, {(kct_pkg::CNT_W-1){1'b1}}};
    localparam logic signed [kct_pkg::CNT_W-1:0] COUNT_MIN =
        {1'b1, {(kct_pkg::CNT_W-1){1'b0}}};
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        kct_pkg::status_t                 status;
        logic signed [kct_pkg::CNT_W-1:0] count;
    } tally_t;

    // Our own copy of the table contents.
    logic [kct_pkg::KEY_BITS-1:0]     table_keys   [kct_pkg::CAPACITY];
    logic signed [kct_pkg::CNT_W-1:0] table_counts [kct_pkg::CAPACITY];
    int                               table_fill = 0;

    tally_t pending_tallies[$];
    int     faults = 0;
    int     results_seen = 0;

    // Applies one request to the table copy and returns the result it must give.
    function automatic tally_t tally_command(logic [1:0] op,
                                             logic [kct_pkg::KEY_BITS-1:0] key,
                                             logic signed [kct_pkg::CNT_W-1:0] qty);
        tally_t                         res;
        int                             slot;
        logic signed [kct_pkg::CNT_W:0] sum;
        res.status = kct_pkg::STAT_DONE;
        res.count  = '0;
        slot = -1;
        // Only slots in use are searched, lowest first.
        for (int i = 0; i < table_fill && slot < 0; i++)
        begin
            if (table_keys[i] == key)
                slot = i;
        end
        case (op)
            kct_pkg::OP_ADD:
            begin
                if (slot >= 0)
                begin
                    // Saturate on overflow in either direction.
                    sum = {table_counts[slot][kct_pkg::CNT_W-1], table_counts[slot]}
                        + {qty[kct_pkg::CNT_W-1], qty};
                    if (sum[kct_pkg::CNT_W] != sum[kct_pkg::CNT_W-1])
                        table_counts[slot] = sum[kct_pkg::CNT_W] ? COUNT_MIN : COUNT_MAX;
                    else
                        table_counts[slot] = sum[kct_pkg::CNT_W-1:0];
                    res.count = table_counts[slot];
                end
                else if (table_fill < kct_pkg::CAPACITY)
                begin
                    table_keys[table_fill]   = key;
                    table_counts[table_fill] = qty;
                    table_fill++;
                    res.count = qty;
                end
                else
                    res.status = kct_pkg::STAT_FULL;
            end
            kct_pkg::OP_UPDATE:
            begin
                if (slot >= 0)
                begin
                    table_counts[slot] = qty;
                    res.count = qty;
                end
                else
                    res.status = kct_pkg::STAT_NOT_FOUND;
            end
            kct_pkg::OP_QUERY:
            begin
                if (slot >= 0)
                    res.count = table_counts[slot];
                else
                    res.status = kct_pkg::STAT_NOT_FOUND;
            end
            // The reserved opcode leaves the table alone and reports done with zero.
            default: ;
        endcase
        return res;
    endfunction

    // Both channels are sampled at the rising edge, before the edge's updates land.
    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        if (!rst_n)
        begin
            table_fill = 0;
            pending_tallies.delete();
        end
        else
        begin
            // Results first: a result never belongs to the request taken at the same edge.
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_tallies.size() == 0)
                begin
                    if (faults < REPORT_LIMIT)
                        $display("result %0d: status %0d count %0d with no request waiting",
                                 results_seen, m_tuser, $signed(m_tdata));
                    faults++;
                end
                else
                begin
                    want = pending_tallies.pop_front();
                    if (m_tuser != want.status || m_tdata != want.count)
                    begin
                        if (faults < REPORT_LIMIT)
                            $display({"result %0d: expected status %0d count %0d, ",
                                      "got status %0d count %0d"},
                                     results_seen, want.status, want.count,
                                     m_tuser, $signed(m_tdata));
                        faults++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_tallies.push_back(
                    tally_command(s_tuser, s_tdata[kct_pkg::KEY_BITS-1:0],
                                  $signed(s_tdata[95:64])));
        end
        fault_count     <= faults;
        pending_results <= pending_tallies.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the keyed count table: clock, reset, request stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [63:0] KEY_ZERO = 64'h0;
    localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] QTY_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] QTY_MIN = 32'h8000_0000;
    localparam logic [31:0] QTY_NEG_ONE = 32'hFFFF_FFFF;
    localparam int DRAIN_CYCLES = 140;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;    // [63:0] item_key, [95:64] quantity
    logic [1:0]  s_tuser = '0;    // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] count_out
    logic [1:0]  m_tuser;         // [1:0] status
    int          fault_count;
    int          pending_results;

    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 54;

    // Keys that were ever sent with an add; the first CAPACITY of them sit in the table.
    logic [63:0] known_keys[$];

    keyed_count_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    keyed_count_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fault_count     (fault_count),
        .pending_results (pending_results)
    );

    always #1 clk = ~clk;

    // The result side stalls at random, one decision per cycle.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Sends one request, with a random idle gap ahead of it; returns at the accepting edge.
    task automatic issue(logic [1:0] op, logic [63:0] key, logic [31:0] qty);
        bit seen;
        seen = 1'b0;
        if (op == kct_pkg::OP_ADD)
        begin
            foreach (known_keys[i])
                if (known_keys[i] == key)
                    seen = 1'b1;
            if (!seen)
                known_keys.push_back(key);
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qty, key};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic on keys the table holds, with fresh keys and near misses.
    task automatic run_random(int count);
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] qty;
        int unsigned roll;
        int unsigned span;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                op = kct_pkg::OP_ADD;
            else if (roll < 65)
                op = kct_pkg::OP_UPDATE;
            else if (roll < 92)
                op = kct_pkg::OP_QUERY;
            else
                op = OP_RESERVED;

            roll = $urandom_range(99);
            if (known_keys.size() == 0 || (op == kct_pkg::OP_ADD && roll < 50) || roll >= 92)
                key = {$urandom, $urandom};
            else
            begin
                span = (known_keys.size() < kct_pkg::CAPACITY) ? known_keys.size()
                                                               : kct_pkg::CAPACITY;
                if (roll < 80)
                    key = known_keys[$urandom_range(span - 1)];
                else
                    key = known_keys[$urandom_range(known_keys.size() - 1)];
                // A single flipped bit makes a key that is almost surely absent.
                if (roll >= 86)
                    key[$urandom_range(63)] ^= 1'b1;
            end

            roll = $urandom_range(99);
            if (roll < 8)
                qty = QTY_MAX;
            else if (roll < 16)
                qty = QTY_MIN;
            else if (roll < 22)
                qty = 32'd100;
            else if (roll < 28)
                qty = QTY_NEG_ONE;
            else if (roll < 32)
                qty = '0;
            else if (roll < 55)
                qty = $urandom_range(2000) - 1000;
            else
                qty = $urandom;

            issue(op, key, qty);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: empty table, saturation both ways, reserved opcode, key extremes.
        issue(kct_pkg::OP_QUERY,  KEY_ZERO, 32'd5);
        issue(kct_pkg::OP_UPDATE, KEY_ZERO, 32'd7);
        issue(kct_pkg::OP_ADD,    KEY_ZERO, QTY_MAX);
        issue(kct_pkg::OP_ADD,    KEY_ZERO, 32'd1);
        issue(kct_pkg::OP_ADD,    KEY_ONES, QTY_MIN);
        issue(kct_pkg::OP_ADD,    KEY_ONES, QTY_NEG_ONE);
        issue(kct_pkg::OP_QUERY,  KEY_ONES, QTY_MAX);
        issue(kct_pkg::OP_UPDATE, KEY_ONES, 32'd100);
        issue(kct_pkg::OP_ADD,    KEY_ONES, QTY_NEG_ONE);
        issue(OP_RESERVED,        KEY_ZERO, 32'd12345);
        issue(kct_pkg::OP_QUERY,  KEY_ZERO, '0);
        issue(kct_pkg::OP_ADD,    64'h8000_0000_0000_0000, '0);
        issue(kct_pkg::OP_QUERY,  64'h7FFF_FFFF_FFFF_FFFF, '0);
        issue(kct_pkg::OP_UPDATE, KEY_ZERO, QTY_MIN);
        issue(kct_pkg::OP_ADD,    KEY_ZERO, QTY_MIN);
        issue(kct_pkg::OP_ADD,    KEY_ZERO, QTY_MAX);
        issue(OP_RESERVED,        KEY_ONES, QTY_MIN);
        issue(kct_pkg::OP_ADD,    64'h5555_5555_5555_5555, 32'h5555_5555);
        issue(kct_pkg::OP_ADD,    64'h5555_5555_5555_5555, 32'h5555_5555);
        issue(kct_pkg::OP_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, '0);
        issue(kct_pkg::OP_UPDATE, 64'h8000_0000_0000_0000, 32'hAAAA_AAAA);
        issue(kct_pkg::OP_QUERY,  64'h8000_0000_0000_0000, QTY_MAX);

        // Random traffic under three idling mixes; the table fills partway through.
        run_random(270);
        send_idle_pct = 54;
        recv_idle_pct = 27;
        run_random(270);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(260);
        s_tvalid <= 1'b0;

        // Let the last request's result come back, then watch for strays.
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && pending_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #1_200_000;
        $display("simulation failed");
        $finish;
    end

endmodule
